FILE: src/rfpd_pkg.sv
// ============================================================================
// rfpd_pkg: shared types and constants of the RF pulse frame decoder
// Register indexes, reset values, result codes and the bound and result
// structures passed between the decoder modules.
// ============================================================================
package rfpd_pkg;

    localparam int DUR_W     = 16;
    localparam int TOL_W     = 7;
    localparam int FACTOR_W  = 8;
    localparam int PROD_W    = DUR_W + FACTOR_W;
    localparam int CFG_IDX_W = 3;
    localparam int PCT_FULL  = 100;

    localparam int FRAME_BITS_DEF = 40;
    localparam int SHORT_BITS     = 5;

    // Frame field positions, counted from the last bit shifted in.
    localparam int ID_LSB  = 12;
    localparam int ID_W    = 28;
    localparam int CH_LSB  = 8;
    localparam int CH_W    = 4;
    localparam int CMD_W   = 8;
    localparam int FIELD_SPAN = ID_LSB + ID_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MARK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MARK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd6;

    localparam logic [DUR_W-1:0] RST_SYNC_MARK  = 16'd4760;
    localparam logic [DUR_W-1:0] RST_SYNC_SPACE = 16'd1520;
    localparam logic [DUR_W-1:0] RST_ZERO_MARK  = 16'd320;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd760;
    localparam logic [DUR_W-1:0] RST_ONE_MARK   = 16'd720;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 16'd360;
    localparam logic [TOL_W-1:0] RST_TOLERANCE  = 7'd25;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SYNC_ERR   = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd3;

    localparam logic [1:0] KIND_UP    = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_DOWN  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [CMD_W-1:0] CMD_UP   = 8'h11;
    localparam logic [CMD_W-1:0] CMD_STOP = 8'h55;
    localparam logic [CMD_W-1:0] CMD_DOWN = 8'h33;

    // Acceptance window of one expected duration, scaled by 100.
    typedef struct packed {
        logic [PROD_W-1:0] lo;
        logic [PROD_W-1:0] hi;
    } bound_t;

    typedef struct packed {
        bound_t sync_mark;
        bound_t sync_space;
        bound_t zero_mark;
        bound_t zero_space;
        bound_t one_mark;
        bound_t one_space;
    } bounds_t;

    typedef struct packed {
        logic sync_mark;
        logic sync_space;
        logic zero_mark;
        logic zero_space;
        logic one_mark;
        logic one_space;
    } fit_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  remote_id;
        logic [CH_W-1:0]  channel;
        logic [CMD_W-1:0] command;
        logic [1:0]       command_kind;
    } result_t;

endpackage

FILE: src/rfpd_cfg_regs.sv
// ============================================================================
// rfpd_cfg_regs: configuration registers and duration windows
// Holds the timing registers and registers, for every expected duration,
// the window bounds e*(100-t) and e*(100+t) used by the classifier.
// ============================================================================
module rfpd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [rfpd_pkg::DUR_W-1:0]       wr_data,
    output rfpd_pkg::bounds_t                bounds
);

    logic [rfpd_pkg::DUR_W-1:0] sync_mark_reg;
    logic [rfpd_pkg::DUR_W-1:0] sync_space_reg;
    logic [rfpd_pkg::DUR_W-1:0] zero_mark_reg;
    logic [rfpd_pkg::DUR_W-1:0] zero_space_reg;
    logic [rfpd_pkg::DUR_W-1:0] one_mark_reg;
    logic [rfpd_pkg::DUR_W-1:0] one_space_reg;
    logic [rfpd_pkg::TOL_W-1:0] tolerance_reg;

    logic [rfpd_pkg::FACTOR_W-1:0] lo_factor;
    logic [rfpd_pkg::FACTOR_W-1:0] hi_factor;
    rfpd_pkg::bounds_t             bounds_next;
    rfpd_pkg::bounds_t             bounds_reg;

    function automatic rfpd_pkg::bound_t make_bound(
        input logic [rfpd_pkg::DUR_W-1:0]    expected,
        input logic [rfpd_pkg::FACTOR_W-1:0] lo_f,
        input logic [rfpd_pkg::FACTOR_W-1:0] hi_f
    );
        rfpd_pkg::bound_t b;
        b.lo = rfpd_pkg::PROD_W'(expected) * rfpd_pkg::PROD_W'(lo_f);
        b.hi = rfpd_pkg::PROD_W'(expected) * rfpd_pkg::PROD_W'(hi_f);
        return b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mark_reg  <= rfpd_pkg::RST_SYNC_MARK;
            sync_space_reg <= rfpd_pkg::RST_SYNC_SPACE;
            zero_mark_reg  <= rfpd_pkg::RST_ZERO_MARK;
            zero_space_reg <= rfpd_pkg::RST_ZERO_SPACE;
            one_mark_reg   <= rfpd_pkg::RST_ONE_MARK;
            one_space_reg  <= rfpd_pkg::RST_ONE_SPACE;
            tolerance_reg  <= rfpd_pkg::RST_TOLERANCE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rfpd_pkg::CFG_SYNC_MARK:  sync_mark_reg  <= wr_data;
                rfpd_pkg::CFG_SYNC_SPACE: sync_space_reg <= wr_data;
                rfpd_pkg::CFG_ZERO_MARK:  zero_mark_reg  <= wr_data;
                rfpd_pkg::CFG_ZERO_SPACE: zero_space_reg <= wr_data;
                rfpd_pkg::CFG_ONE_MARK:   one_mark_reg   <= wr_data;
                rfpd_pkg::CFG_ONE_SPACE:  one_space_reg  <= wr_data;
                rfpd_pkg::CFG_TOLERANCE:  tolerance_reg  <= wr_data[rfpd_pkg::TOL_W-1:0];
                default:                  ;
            endcase
        end
    end

    // At a tolerance of 100 percent or more the lower bound is zero.
    always_comb
    begin
        if (tolerance_reg >= rfpd_pkg::TOL_W'(rfpd_pkg::PCT_FULL))
        begin
            lo_factor = '0;
        end
        else
        begin
            lo_factor = rfpd_pkg::FACTOR_W'(rfpd_pkg::PCT_FULL)
                      - rfpd_pkg::FACTOR_W'(tolerance_reg);
        end
        hi_factor = rfpd_pkg::FACTOR_W'(rfpd_pkg::PCT_FULL)
                  + rfpd_pkg::FACTOR_W'(tolerance_reg);

        bounds_next.sync_mark  = make_bound(sync_mark_reg,  lo_factor, hi_factor);
        bounds_next.sync_space = make_bound(sync_space_reg, lo_factor, hi_factor);
        bounds_next.zero_mark  = make_bound(zero_mark_reg,  lo_factor, hi_factor);
        bounds_next.zero_space = make_bound(zero_space_reg, lo_factor, hi_factor);
        bounds_next.one_mark   = make_bound(one_mark_reg,   lo_factor, hi_factor);
        bounds_next.one_space  = make_bound(one_space_reg,  lo_factor, hi_factor);
    end

    always_ff @(posedge clk)
    begin
        bounds_reg <= bounds_next;
    end

    assign bounds = bounds_reg;

endmodule

FILE: src/rfpd_classify.sv
// ============================================================================
// rfpd_classify: duration window compare
// Checks one measured duration against all six expected-duration windows.
// ============================================================================
module rfpd_classify (
    input  logic [rfpd_pkg::DUR_W-1:0] duration,
    input  rfpd_pkg::bounds_t          bounds,
    output rfpd_pkg::fit_t             fit
);

    logic [rfpd_pkg::PROD_W-1:0] scaled;
    logic [rfpd_pkg::PROD_W-1:0] scaled_top;

    // floor(lo/100) <= d holds when lo <= 100*d + 99, and
    // d <= floor(hi/100) holds when 100*d <= hi.
    function automatic logic in_window(
        input rfpd_pkg::bound_t           b,
        input logic [rfpd_pkg::PROD_W-1:0] s,
        input logic [rfpd_pkg::PROD_W-1:0] s_top
    );
        return (b.lo <= s_top) && (s <= b.hi);
    endfunction

    always_comb
    begin
        scaled     = rfpd_pkg::PROD_W'(duration) * rfpd_pkg::PROD_W'(rfpd_pkg::PCT_FULL);
        scaled_top = scaled + rfpd_pkg::PROD_W'(rfpd_pkg::PCT_FULL - 1);

        fit.sync_mark  = in_window(bounds.sync_mark,  scaled, scaled_top);
        fit.sync_space = in_window(bounds.sync_space, scaled, scaled_top);
        fit.zero_mark  = in_window(bounds.zero_mark,  scaled, scaled_top);
        fit.zero_space = in_window(bounds.zero_space, scaled, scaled_top);
        fit.one_mark   = in_window(bounds.one_mark,   scaled, scaled_top);
        fit.one_space  = in_window(bounds.one_space,  scaled, scaled_top);
    end

endmodule

FILE: src/rfpd_frame_fsm.sv
// ============================================================================
// rfpd_frame_fsm: frame sequencer
// Tracks sync and bit phases, shifts in decoded bits and forms the result
// item for a finished or broken frame.
// ============================================================================
module rfpd_frame_fsm #(
    parameter int FRAME_BITS = rfpd_pkg::FRAME_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               level,
    input  rfpd_pkg::fit_t     fit,
    output logic               has_result,
    output rfpd_pkg::result_t  result
);

    localparam int BITS_W = $clog2(FRAME_BITS + 1);
    localparam int EXT_W  = (FRAME_BITS > rfpd_pkg::FIELD_SPAN) ? FRAME_BITS
                                                                : rfpd_pkg::FIELD_SPAN;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SYNC_SPACE,
        PH_MARK,
        PH_SPACE
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [BITS_W-1:0]       bits_reg, bits_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [1:0]              mclass_reg, mclass_next;

    logic                    bit_ok;
    logic                    bit_val;
    logic [BITS_W-1:0]       bits_inc;
    logic [FRAME_BITS-1:0]   frame_shifted;
    logic [EXT_W-1:0]        frame_ext;
    logic [rfpd_pkg::CMD_W-1:0] cmd;
    logic [1:0]              abort_status;

    always_comb
    begin
        // A pair that fits both bit shapes is taken as a zero.
        bit_ok  = 1'b0;
        bit_val = 1'b0;
        if (!level && mclass_reg[0] && fit.zero_space)
        begin
            bit_ok = 1'b1;
        end
        else if (!level && mclass_reg[1] && fit.one_space)
        begin
            bit_ok  = 1'b1;
            bit_val = 1'b1;
        end

        bits_inc      = bits_reg + BITS_W'(1);
        frame_shifted = {frame_reg[FRAME_BITS-2:0], bit_val};
        frame_ext     = EXT_W'(frame_shifted);
        cmd           = frame_ext[rfpd_pkg::CMD_W-1:0];
        abort_status  = (bits_reg > BITS_W'(rfpd_pkg::SHORT_BITS))
                      ? rfpd_pkg::ST_INCOMPLETE : rfpd_pkg::ST_TOO_SHORT;

        phase_next  = phase_reg;
        bits_next   = bits_reg;
        frame_next  = frame_reg;
        mclass_next = mclass_reg;
        has_result  = 1'b0;
        result.status       = rfpd_pkg::ST_OK;
        result.remote_id    = '0;
        result.channel      = '0;
        result.command      = '0;
        result.command_kind = rfpd_pkg::KIND_OTHER;

        case (phase_reg)
            PH_IDLE:
            begin
                if (level && fit.sync_mark)
                begin
                    phase_next = PH_SYNC_SPACE;
                end
            end
            PH_SYNC_SPACE:
            begin
                if (!level && fit.sync_space)
                begin
                    phase_next  = PH_MARK;
                    bits_next   = '0;
                    frame_next  = '0;
                    mclass_next = '0;
                end
                else
                begin
                    has_result    = 1'b1;
                    result.status = rfpd_pkg::ST_SYNC_ERR;
                    phase_next    = PH_IDLE;
                end
            end
            PH_MARK:
            begin
                if (level && (fit.zero_mark || fit.one_mark))
                begin
                    mclass_next = {fit.one_mark, fit.zero_mark};
                    phase_next  = PH_SPACE;
                end
                else
                begin
                    has_result    = 1'b1;
                    result.status = abort_status;
                    phase_next    = PH_IDLE;
                    bits_next     = '0;
                    frame_next    = '0;
                    mclass_next   = '0;
                end
            end
            PH_SPACE:
            begin
                mclass_next = '0;
                if (!bit_ok)
                begin
                    has_result    = 1'b1;
                    result.status = abort_status;
                    phase_next    = PH_IDLE;
                    bits_next     = '0;
                    frame_next    = '0;
                end
                else if (bits_inc < BITS_W'(FRAME_BITS))
                begin
                    phase_next = PH_MARK;
                    bits_next  = bits_inc;
                    frame_next = frame_shifted;
                end
                else
                begin
                    has_result       = 1'b1;
                    result.status    = rfpd_pkg::ST_OK;
                    result.remote_id = frame_ext[rfpd_pkg::ID_LSB +: rfpd_pkg::ID_W];
                    result.channel   = frame_ext[rfpd_pkg::CH_LSB +: rfpd_pkg::CH_W];
                    result.command   = cmd;
                    case (cmd)
                        rfpd_pkg::CMD_UP:   result.command_kind = rfpd_pkg::KIND_UP;
                        rfpd_pkg::CMD_STOP: result.command_kind = rfpd_pkg::KIND_STOP;
                        rfpd_pkg::CMD_DOWN: result.command_kind = rfpd_pkg::KIND_DOWN;
                        default:            result.command_kind = rfpd_pkg::KIND_OTHER;
                    endcase
                    phase_next = PH_IDLE;
                    bits_next  = '0;
                    frame_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bits_reg   <= '0;
            frame_reg  <= '0;
            mclass_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bits_reg   <= bits_next;
            frame_reg  <= frame_next;
            mclass_reg <= mclass_next;
        end
    end

endmodule

FILE: src/rfpd_out_stage.sv
// ============================================================================
// rfpd_out_stage: result register
// Holds one result item until the receiver takes it.
// ============================================================================
module rfpd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rfpd_pkg::result_t  result,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               free,
    output rfpd_pkg::result_t  held
);

    logic              valid_reg, valid_next;
    rfpd_pkg::result_t data_reg;

    always_comb
    begin
        free       = !valid_reg || !out_stall;
        valid_next = load || (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

FILE: src/rf_pulse_frame_decoder_unit.sv
// ============================================================================
// rf_pulse_frame_decoder_unit: pulse-width remote frame decoder
// Decodes sync plus FRAME_BITS mark/space bit pairs into remote id,
// channel and command, or reports why a frame broke off.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries one measured pulse per item:
//   level (1 mark, 0 space) and duration_us. Output channel
//   (out_valid/out_stall) carries a result item for each completed frame
//   and for each sync or bit error; other pulses give no result.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   is always ready and should be written while no pulses are in flight.
//   Window bounds are registered behind the timing registers.
//   An accepted pulse is held in the input register, and its result is
//   loaded into the output register when the held pulse moves on.
//   One pulse is taken per cycle unless in_stall is high; the FSM steps with it.
//   When the receiver stalls with a result pending, a pulse that would make
//   another result waits in the input register and in_stall rises; pulses
//   that produce no result still pass.
//   Reset loads the default timing values, clears the frame state to idle
//   and empties both registers.
// ============================================================================
module rf_pulse_frame_decoder_unit #(
    parameter int FRAME_BITS = rfpd_pkg::FRAME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             level,
    input  logic [rfpd_pkg::DUR_W-1:0]       duration_us,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [rfpd_pkg::ID_W-1:0]        remote_id,
    output logic [rfpd_pkg::CH_W-1:0]        channel,
    output logic [rfpd_pkg::CMD_W-1:0]       command,
    output logic [1:0]                       command_kind,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfpd_pkg::DUR_W-1:0]       cfg_data
);

    logic                        in_valid_reg, in_valid_next;
    logic                        level_reg;
    logic [rfpd_pkg::DUR_W-1:0]  duration_reg;

    rfpd_pkg::bounds_t  bounds;
    rfpd_pkg::fit_t     fit;
    rfpd_pkg::result_t  result;
    rfpd_pkg::result_t  held;
    logic               has_result;
    logic               out_free;
    logic               step;
    logic               in_take;

    assign cfg_ready = 1'b1;

    rfpd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .bounds   (bounds)
    );

    rfpd_classify u_classify (
        .duration (duration_reg),
        .bounds   (bounds),
        .fit      (fit)
    );

    rfpd_frame_fsm #(
        .FRAME_BITS (FRAME_BITS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .level      (level_reg),
        .fit        (fit),
        .has_result (has_result),
        .result     (result)
    );

    rfpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && has_result),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (out_free),
        .held      (held)
    );

    // The held pulse moves on unless it makes a result that has nowhere to go.
    always_comb
    begin
        step          = in_valid_reg && (!has_result || out_free);
        in_stall      = in_valid_reg && !step;
        in_take       = in_valid && !in_stall;
        in_valid_next = in_take || (in_valid_reg && !step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            level_reg    <= level;
            duration_reg <= duration_us;
        end
    end

    assign status       = held.status;
    assign remote_id    = held.remote_id;
    assign channel      = held.channel;
    assign command      = held.command;
    assign command_kind = held.command_kind;

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != rfpd_pkg::ST_OK) |->
            (remote_id == '0 && channel == '0 && command == '0
             && command_kind == rfpd_pkg::KIND_OTHER))
        else $error("error result carries frame fields");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could take an item");

    a_result_from_held_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a pulse in the input register");

    a_ok_kind_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rfpd_pkg::ST_OK && command == rfpd_pkg::CMD_UP)
            |-> (command_kind == rfpd_pkg::KIND_UP))
        else $error("up command not classified as up");

endmodule

FILE: tb/sv/rf_pulse_frame_decoder_unit_test.sv
// ============================================================================
// rf_pulse_frame_decoder_unit_test: self-checking bench for the pulse decoder
// Feeds measured pulses, from directed frames and breaks to random frame
// traffic under several timing settings. An internal decoder predicts every
// status report and each report is checked field by field.
// ============================================================================
module rf_pulse_frame_decoder_unit_test;
    import rfpd_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_PAUSE     = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PULSES   = 100;
    localparam int RANDOM_REPORTS  = 16;
    localparam int DUR_MAX         = 65535;

    typedef enum logic [1:0] {
        WAIT_SYNC_MARK,
        WAIT_SYNC_SPACE,
        WAIT_MARK,
        WAIT_SPACE
    } decode_phase_e;

    typedef enum logic [2:0] {
        BRK_NONE,
        BRK_MARK_LEVEL,
        BRK_MARK_LEN,
        BRK_SPACE_LEVEL,
        BRK_SPACE_LEN
    } frame_break_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 level = 1'b0;
    logic [DUR_W-1:0]     duration_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [ID_W-1:0]      remote_id;
    logic [CH_W-1:0]      channel;
    logic [CMD_W-1:0]     command;
    logic [1:0]           command_kind;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_data = '0;

    // Decoder copy: timing registers, tolerance and frame state.
    logic [DUR_W-1:0] len_cfg [0:5];
    logic [TOL_W-1:0] tol_cfg;
    decode_phase_e    phase_q;
    int unsigned      bits_in;
    logic [63:0]      shift_reg;
    logic [1:0]       mark_fit;

    result_t reports_due [$];
    int      mismatches = 0;
    int      reports_seen = 0;
    int      pulses_taken = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    rf_pulse_frame_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .level        (level),
        .duration_us  (duration_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .remote_id    (remote_id),
        .channel      (channel),
        .command      (command),
        .command_kind (command_kind),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Acceptance window of an expected duration under the current tolerance.
    function automatic void window(input logic [DUR_W-1:0] e, output int unsigned lo,
                                   output int unsigned hi);
        int unsigned t;
        int unsigned ev;
        t  = tol_cfg;
        ev = e;
        lo = (t >= PCT_FULL) ? 0 : (ev * (PCT_FULL - t)) / PCT_FULL;
        hi = (ev * (PCT_FULL + t)) / PCT_FULL;
    endfunction

    function automatic bit fits(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] e);
        int unsigned lo;
        int unsigned hi;
        int unsigned dv;
        window(e, lo, hi);
        dv = d;
        return (dv >= lo) && (dv <= hi);
    endfunction

    // Random duration inside the window of timing register idx.
    function automatic logic [DUR_W-1:0] pick_len(input logic [CFG_IDX_W-1:0] idx);
        int unsigned lo;
        int unsigned hi;
        window(len_cfg[idx], lo, hi);
        if (hi > DUR_MAX)
            hi = DUR_MAX;
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    // Advances the decoder copy by one pulse and queues the report it causes.
    function automatic void decode_pulse(input logic lv, input logic [DUR_W-1:0] d);
        result_t r;
        bit      broken;
        bit      done;
        logic    bit_val;
        r = '0;
        r.command_kind = KIND_OTHER;
        broken = 1'b0;
        done = 1'b0;
        bit_val = 1'b0;
        case (phase_q)
            WAIT_SYNC_MARK:
            begin
                if (lv && fits(d, len_cfg[CFG_SYNC_MARK]))
                    phase_q = WAIT_SYNC_SPACE;
            end
            WAIT_SYNC_SPACE:
            begin
                if (!lv && fits(d, len_cfg[CFG_SYNC_SPACE]))
                begin
                    phase_q = WAIT_MARK;
                    bits_in = 0;
                    shift_reg = '0;
                    mark_fit = '0;
                end
                else
                begin
                    r.status = ST_SYNC_ERR;
                    reports_due.push_back(r);
                    phase_q = WAIT_SYNC_MARK;
                end
            end
            WAIT_MARK:
            begin
                if (!lv)
                    broken = 1'b1;
                else
                begin
                    mark_fit = {fits(d, len_cfg[CFG_ONE_MARK]), fits(d, len_cfg[CFG_ZERO_MARK])};
                    if (mark_fit == 2'b00)
                        broken = 1'b1;
                    else
                        phase_q = WAIT_SPACE;
                end
            end
            default:
            begin
                // A pair that fits both bit shapes decodes as a zero.
                if (lv)
                    broken = 1'b1;
                else if (mark_fit[0] && fits(d, len_cfg[CFG_ZERO_SPACE]))
                    bit_val = 1'b0;
                else if (mark_fit[1] && fits(d, len_cfg[CFG_ONE_SPACE]))
                    bit_val = 1'b1;
                else
                    broken = 1'b1;
                if (!broken)
                begin
                    shift_reg = {shift_reg[62:0], bit_val};
                    bits_in++;
                    mark_fit = '0;
                    if (bits_in < FRAME_BITS_DEF)
                        phase_q = WAIT_MARK;
                    else
                        done = 1'b1;
                end
            end
        endcase
        if (broken)
        begin
            r.status = (bits_in > SHORT_BITS) ? ST_INCOMPLETE : ST_TOO_SHORT;
            reports_due.push_back(r);
            phase_q = WAIT_SYNC_MARK;
            bits_in = 0;
            shift_reg = '0;
            mark_fit = '0;
        end
        if (done)
        begin
            r.status = ST_OK;
            r.remote_id = shift_reg[ID_LSB +: ID_W];
            r.channel = shift_reg[CH_LSB +: CH_W];
            r.command = shift_reg[CMD_W-1:0];
            case (r.command)
                CMD_UP:   r.command_kind = KIND_UP;
                CMD_STOP: r.command_kind = KIND_STOP;
                CMD_DOWN: r.command_kind = KIND_DOWN;
                default:  r.command_kind = KIND_OTHER;
            endcase
            reports_due.push_back(r);
            phase_q = WAIT_SYNC_MARK;
            bits_in = 0;
            shift_reg = '0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen++;
            if (reports_due.size() == 0)
            begin
                $error("report item arrived with nothing pending");
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("remote_id", 32'(want.remote_id), 32'(remote_id));
                compare_field("channel", 32'(want.channel), 32'(channel));
                compare_field("command", 32'(want.command), 32'(command));
                compare_field("command_kind", 32'(want.command_kind), 32'(command_kind));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pulse(input logic lv, input logic [DUR_W-1:0] d);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        level <= lv;
        duration_us <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_pulse(lv, d);
        pulses_taken++;
    endtask

    // Waits until every report is in, then lets pulses without a report clear.
    task automatic settle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [DUR_W-1:0] sync_mark, sync_space,
                                zero_mark, zero_space, one_mark, one_space,
                                input logic [TOL_W-1:0] tol);
        logic [DUR_W-1:0] vals [0:6];
        int i;
        vals[CFG_SYNC_MARK]  = sync_mark;
        vals[CFG_SYNC_SPACE] = sync_space;
        vals[CFG_ZERO_MARK]  = zero_mark;
        vals[CFG_ZERO_SPACE] = zero_space;
        vals[CFG_ONE_MARK]   = one_mark;
        vals[CFG_ONE_SPACE]  = one_space;
        vals[CFG_TOLERANCE]  = {{(DUR_W-TOL_W){1'b0}}, tol};
        for (i = 0; i <= CFG_TOLERANCE; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (i == CFG_TOLERANCE)
                tol_cfg = tol;
            else
                len_cfg[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Sync, good_bits well-formed bit pairs taken MSB first, then the break.
    task automatic send_frame(input logic [39:0] frame, input int good_bits,
                              input frame_break_e brk);
        int i;
        logic b;
        send_pulse(1'b1, pick_len(CFG_SYNC_MARK));
        send_pulse(1'b0, pick_len(CFG_SYNC_SPACE));
        for (i = 0; i < good_bits; i++)
        begin
            b = frame[39 - i];
            send_pulse(1'b1, pick_len(b ? CFG_ONE_MARK : CFG_ZERO_MARK));
            send_pulse(1'b0, pick_len(b ? CFG_ONE_SPACE : CFG_ZERO_SPACE));
        end
        case (brk)
            BRK_MARK_LEVEL:
                send_pulse(1'b0, DUR_W'($urandom));
            BRK_MARK_LEN:
                send_pulse(1'b1, $urandom_range(1, 0) ? 16'd0 : 16'($urandom));
            BRK_SPACE_LEVEL:
            begin
                send_pulse(1'b1, pick_len(CFG_ZERO_MARK));
                send_pulse(1'b1, DUR_W'($urandom));
            end
            BRK_SPACE_LEN:
            begin
                send_pulse(1'b1, pick_len(CFG_ZERO_MARK));
                send_pulse(1'b0, $urandom_range(1, 0) ? 16'hFFFF : 16'($urandom));
            end
            default:
                ;
        endcase
    endtask

    task automatic test_idle_and_sync_errors();
        // Pulses that are no sync mark are dropped silently while idle.
        send_pulse(1'b0, 16'hFFFF);
        send_pulse(1'b1, 16'h0000);
        send_pulse(1'b1, 16'hFFFF);
        send_pulse(1'b0, 16'h0000);
        // Sync mark at the lower window edge, space just above its window.
        send_pulse(1'b1, 16'd3570);
        send_pulse(1'b0, 16'd1901);
        // Sync mark at the upper edge, then a mark where the space belongs.
        send_pulse(1'b1, 16'd5950);
        send_pulse(1'b1, RST_SYNC_SPACE);
    endtask

    task automatic test_frame_kinds();
        send_frame(40'hFF_FFFF_FFFF, FRAME_BITS_DEF, BRK_NONE);
        send_frame({28'h0, 4'h0, CMD_UP}, FRAME_BITS_DEF, BRK_NONE);
        send_frame({28'h5A5_A5A5, 4'h9, CMD_STOP}, FRAME_BITS_DEF, BRK_NONE);
        send_frame({28'hA5A_5A5A, 4'h6, CMD_DOWN}, FRAME_BITS_DEF, BRK_NONE);
    endtask

    task automatic test_broken_frames();
        send_frame(40'({$urandom, $urandom}), 0, BRK_MARK_LEN);
        send_frame(40'({$urandom, $urandom}), SHORT_BITS, BRK_MARK_LEVEL);
        send_frame(40'({$urandom, $urandom}), SHORT_BITS + 1, BRK_SPACE_LEN);
        send_frame(40'({$urandom, $urandom}), FRAME_BITS_DEF - 1, BRK_SPACE_LEVEL);
    endtask

    task automatic test_register_extremes();
        settle();
        // Zero tolerance: only exact durations, at both ends of the range.
        program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 7'd0);
        send_frame(40'({$urandom, $urandom}), FRAME_BITS_DEF, BRK_NONE);
        send_pulse(1'b1, 16'hFFFE);
        send_pulse(1'b1, 16'hFFFF);
        send_pulse(1'b0, 16'h0001);
        settle();
        // Full tolerance, identical bit shapes: every pair is ambiguous.
        program_regs(16'd1000, 16'd1000, 16'd500, 16'd500, 16'd500, 16'd500, 7'd100);
        send_frame(40'hFF_FFFF_FFFF, FRAME_BITS_DEF, BRK_NONE);
        send_frame(40'({$urandom, $urandom}), 3, BRK_SPACE_LEVEL);
        settle();
        program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'd100);
        send_frame(40'({$urandom, $urandom}), FRAME_BITS_DEF, BRK_NONE);
        send_pulse(1'b1, 16'd0);
        send_pulse(1'b1, 16'd0);
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input bit random_timing, input int tol_max);
        int          pulse_goal;
        int          report_goal;
        int          pick;
        int          n;
        logic [39:0] frame;
        settle();
        if (random_timing)
            program_regs(DUR_W'($urandom_range(9000, 60)), DUR_W'($urandom_range(9000, 60)),
                         DUR_W'($urandom_range(9000, 60)), DUR_W'($urandom_range(9000, 60)),
                         DUR_W'($urandom_range(9000, 60)), DUR_W'($urandom_range(9000, 60)),
                         TOL_W'($urandom_range(tol_max, 0)));
        else
            program_regs(RST_SYNC_MARK, RST_SYNC_SPACE, RST_ZERO_MARK, RST_ZERO_SPACE,
                         RST_ONE_MARK, RST_ONE_SPACE, RST_TOLERANCE);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        pulse_goal = pulses_taken + RANDOM_PULSES;
        report_goal = reports_seen + reports_due.size() + RANDOM_REPORTS;
        while (pulses_taken < pulse_goal || reports_seen + reports_due.size() < report_goal)
        begin
            pick = $urandom_range(99, 0);
            frame = 40'({$urandom, $urandom});
            case ($urandom_range(3, 0))
                0: frame[CMD_W-1:0] = CMD_UP;
                1: frame[CMD_W-1:0] = CMD_STOP;
                2: frame[CMD_W-1:0] = CMD_DOWN;
                default: ;
            endcase
            if (pick < 15)
            begin
                for (n = $urandom_range(4, 1); n > 0; n--)
                    send_pulse(1'($urandom_range(1, 0)), DUR_W'($urandom));
            end
            else if (pick < 25)
            begin
                send_pulse(1'b1, pick_len(CFG_SYNC_MARK));
                send_pulse(1'($urandom_range(1, 0)), DUR_W'($urandom));
            end
            else if (pick < 55)
                send_frame(frame, FRAME_BITS_DEF, BRK_NONE);
            else
            begin
                n = $urandom_range(1, 0) ? $urandom_range(8, 0) : $urandom_range(39, 0);
                case ($urandom_range(3, 0))
                    0: send_frame(frame, n, BRK_MARK_LEVEL);
                    1: send_frame(frame, n, BRK_MARK_LEN);
                    2: send_frame(frame, n, BRK_SPACE_LEVEL);
                    default: send_frame(frame, n, BRK_SPACE_LEN);
                endcase
            end
        end
    endtask

    // The receiver holds off while every pulse pair causes a sync error,
    // so reports back up and the input side has to stall.
    task automatic test_output_backpressure();
        int i;
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 40; i++)
        begin
            send_pulse(1'b1, pick_len(CFG_SYNC_MARK));
            send_pulse(1'b1, DUR_W'($urandom));
        end
    endtask

    initial
    begin
        len_cfg[CFG_SYNC_MARK]  = RST_SYNC_MARK;
        len_cfg[CFG_SYNC_SPACE] = RST_SYNC_SPACE;
        len_cfg[CFG_ZERO_MARK]  = RST_ZERO_MARK;
        len_cfg[CFG_ZERO_SPACE] = RST_ZERO_SPACE;
        len_cfg[CFG_ONE_MARK]   = RST_ONE_MARK;
        len_cfg[CFG_ONE_SPACE]  = RST_ONE_SPACE;
        tol_cfg = RST_TOLERANCE;
        phase_q = WAIT_SYNC_MARK;
        bits_in = 0;
        shift_reg = '0;
        mark_fit = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 69;
        test_idle_and_sync_errors();
        test_frame_kinds();
        test_broken_frames();
        test_register_extremes();
        test_random_traffic(7, 69, 1'b0, 0);
        test_random_traffic(69, 7, 1'b1, 40);
        test_random_traffic(0, 0, 1'b1, 100);
        test_output_backpressure();
        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
